FILE: design/prc_pkg.sv
// Shared types, constants and the arctangent table for the polar/rectangular converter.
// Depends on nothing; every other file of the block imports this package.
`default_nettype none

package prc_pkg;

    // Coordinate width at the ports and CORDIC depth.
    localparam int unsigned DATA_WIDTH = 16;
    localparam int unsigned ITERATIONS = 16;

    // Internal fixed point: coordinates carry GUARD_BITS fraction bits.
    localparam int unsigned GUARD_BITS = 20;
    localparam int unsigned INT_W      = DATA_WIDTH + GUARD_BITS + 4;

    // Angles are held as 32-bit binary units, 2^31 standing for pi.
    localparam int unsigned ANG_W     = 32;
    localparam int unsigned ANG_SHIFT = ANG_W - DATA_WIDTH;

    // Inverse CORDIC gain, Q0.32.
    localparam logic [31:0] GAIN_INV  = 32'd2608131496;
    localparam int unsigned GAIN_SHIFT = 32 - GUARD_BITS;

    localparam int unsigned TABLE_LEN = 32;
    localparam int unsigned IDX_W     = $clog2(TABLE_LEN);
    localparam int unsigned ITER_N    = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

    // Multiply register, prep register, one register per iteration, output register.
    localparam int unsigned LATENCY = ITER_N + 3;

    // Conversion direction codes.
    localparam logic MODE_TO_RECT  = 1'b0;
    localparam logic MODE_TO_POLAR = 1'b1;

    // atan(2^-i) in binary units, 2^32 per full turn.
    localparam logic [31:0] ATAN_BAU [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic                          action;
        logic signed [DATA_WIDTH-1:0]  x_in;
        logic signed [DATA_WIDTH-1:0]  y_in;
        logic        [DATA_WIDTH-2:0]  radius_in;
        logic signed [DATA_WIDTH-1:0]  angle_in;
    } t_prc_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  x_out;
        logic signed [DATA_WIDTH-1:0]  y_out;
        logic        [DATA_WIDTH-1:0]  radius_out;
        logic signed [DATA_WIDTH-1:0]  angle_out;
    } t_prc_out;

    // Working vector that moves down the pipeline.
    typedef struct packed {
        logic                     mode;
        logic                     origin;
        logic signed [INT_W-1:0]  x;
        logic signed [INT_W-1:0]  y;
        logic        [ANG_W-1:0]  ang;
    } t_prc_vec;

endpackage

`default_nettype wire

FILE: design/prc_front.sv
// Front end of the converter: gain pre-scale multiply, then quadrant folding.
// Depends on prc_pkg.
`default_nettype none

module prc_front
    import prc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_prc_in  i_item,
    output logic          o_valid,
    output t_prc_vec      o_vec
);

    localparam int unsigned PROD_W = DATA_WIDTH + 1 + 33;

    logic                      r_mul_valid;
    t_prc_vec                  r_mul;
    t_prc_vec                  n_mul;
    logic                      r_prep_valid;
    t_prc_vec                  r_prep;
    t_prc_vec                  n_prep;

    logic signed [DATA_WIDTH:0] opa;
    logic signed [DATA_WIDTH:0] opb;
    logic signed [32:0]         gain;
    logic signed [PROD_W-1:0]   prod_a;
    logic signed [PROD_W-1:0]   prod_b;

    // Stage 1: scale the start vector by the inverse gain.
    always_comb begin
        gain = $signed({1'b0, GAIN_INV});
        if (i_item.action == MODE_TO_POLAR) begin
            opa = {i_item.x_in[DATA_WIDTH-1], i_item.x_in};
            opb = {i_item.y_in[DATA_WIDTH-1], i_item.y_in};
        end else begin
            opa = $signed({2'b00, i_item.radius_in});
            opb = '0;
        end
        prod_a = PROD_W'(opa) * PROD_W'(gain);
        prod_b = PROD_W'(opb) * PROD_W'(gain);

        n_mul.mode   = i_item.action;
        n_mul.origin = (i_item.action == MODE_TO_POLAR) &&
                       (i_item.x_in == '0) && (i_item.y_in == '0);
        n_mul.x      = INT_W'(prod_a >>> GAIN_SHIFT);
        n_mul.y      = INT_W'(prod_b >>> GAIN_SHIFT);
        n_mul.ang    = ANG_W'($unsigned(i_item.angle_in)) << ANG_SHIFT;
    end

    // Stage 2: fold the problem into the right half plane.
    always_comb begin
        n_prep = r_mul;
        if (r_mul.mode == MODE_TO_RECT) begin
            if (r_mul.ang[ANG_W-1] != r_mul.ang[ANG_W-2]) begin
                n_prep.x   = -r_mul.x;
                n_prep.ang = r_mul.ang ^ (ANG_W'(1) << (ANG_W - 1));
            end
        end else begin
            n_prep.ang = '0;
            if (r_mul.x[INT_W-1]) begin
                n_prep.x   = -r_mul.x;
                n_prep.y   = -r_mul.y;
                n_prep.ang = ANG_W'(1) << (ANG_W - 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid  <= 1'b0;
            r_prep_valid <= 1'b0;
        end else begin
            r_mul_valid  <= i_valid;
            r_prep_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul  <= n_mul;
        r_prep <= n_prep;
    end

    assign o_valid = r_prep_valid;
    assign o_vec   = r_prep;

endmodule

`default_nettype wire

FILE: design/prc_stage.sv
// One CORDIC micro-rotation with its pipeline register.
// Depends on prc_pkg for the vector type and the arctangent table.
`default_nettype none

module prc_stage
    import prc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire logic             i_valid,
    input  wire t_prc_vec         i_vec,
    output logic                  o_valid,
    output t_prc_vec              o_vec
);

    logic                    r_valid;
    t_prc_vec                r_vec;
    t_prc_vec                n_vec;
    logic signed [INT_W-1:0] dx;
    logic signed [INT_W-1:0] dy;
    logic                    sub;

    // Rotation drives the angle to zero; vectoring drives y to zero.
    always_comb begin
        dx    = i_vec.y >>> i_idx;
        dy    = i_vec.x >>> i_idx;
        sub   = (i_vec.mode == MODE_TO_POLAR) ? i_vec.y[INT_W-1] : ~i_vec.ang[ANG_W-1];
        n_vec = i_vec;
        if (sub) begin
            n_vec.x   = i_vec.x - dx;
            n_vec.y   = i_vec.y + dy;
            n_vec.ang = i_vec.ang - ATAN_BAU[i_idx];
        end else begin
            n_vec.x   = i_vec.x + dx;
            n_vec.y   = i_vec.y - dy;
            n_vec.ang = i_vec.ang + ATAN_BAU[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

`default_nettype wire

FILE: design/prc_back.sv
// Output stage: rounds the CORDIC result, saturates it and registers the result.
// Depends on prc_pkg.
`default_nettype none

module prc_back
    import prc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_prc_vec i_vec,
    output logic          o_done,
    output t_prc_out      o_result
);

    localparam int unsigned QW = INT_W + 1 - GUARD_BITS;
    localparam logic signed [QW-1:0] SMAX = QW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic signed [QW-1:0] SMIN = -SMAX - QW'(1);
    localparam logic signed [QW-1:0] UMAX = QW'((64'd1 << DATA_WIDTH) - 64'd1);
    localparam logic signed [INT_W:0] HALF_C = (INT_W+1)'(1) << (GUARD_BITS - 1);
    localparam logic [ANG_W:0] HALF_A = ((ANG_W+1)'(1) << ANG_SHIFT) >> 1;

    logic                    r_done;
    t_prc_out                r_result;
    t_prc_out                n_result;
    logic signed [INT_W:0]   sum_x;
    logic signed [INT_W:0]   sum_y;
    logic signed [QW-1:0]    qx;
    logic signed [QW-1:0]    qy;
    logic        [ANG_W:0]   sum_a;
    logic signed [DATA_WIDTH-1:0] sat_x;
    logic signed [DATA_WIDTH-1:0] sat_y;
    logic        [DATA_WIDTH-1:0] sat_r;

    always_comb begin
        sum_x = (INT_W+1)'(i_vec.x) + HALF_C;
        sum_y = (INT_W+1)'(i_vec.y) + HALF_C;
        qx    = sum_x[INT_W:GUARD_BITS];
        qy    = sum_y[INT_W:GUARD_BITS];
        sum_a = {1'b0, i_vec.ang} + HALF_A;

        if (qx > SMAX) begin
            sat_x = DATA_WIDTH'(SMAX);
        end else if (qx < SMIN) begin
            sat_x = DATA_WIDTH'(SMIN);
        end else begin
            sat_x = qx[DATA_WIDTH-1:0];
        end

        if (qy > SMAX) begin
            sat_y = DATA_WIDTH'(SMAX);
        end else if (qy < SMIN) begin
            sat_y = DATA_WIDTH'(SMIN);
        end else begin
            sat_y = qy[DATA_WIDTH-1:0];
        end

        if (qx > UMAX) begin
            sat_r = DATA_WIDTH'(UMAX);
        end else if (qx < 0) begin
            sat_r = '0;
        end else begin
            sat_r = qx[DATA_WIDTH-1:0];
        end

        n_result = '0;
        if (i_vec.mode == MODE_TO_RECT) begin
            n_result.x_out = sat_x;
            n_result.y_out = sat_y;
        end else if (!i_vec.origin) begin
            n_result.radius_out = sat_r;
            n_result.angle_out  = sum_a[ANG_SHIFT +: DATA_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: design/polar_rectangular_converter_unit.sv
// Top level of the polar/rectangular coordinate converter.
// Depends on prc_pkg, prc_front, prc_stage and prc_back.
//
// Usage:
//   A transaction enters when start is high and busy is low at a rising edge of
//   i_clk. The item travels as i_item: action 0 turns radius_in and angle_in into
//   x_out and y_out, action 1 turns x_in and y_in into radius_out and angle_out
//   (a four-quadrant arctangent; the origin gives zero). Angles are binary units,
//   half a full turn being 2^(DATA_WIDTH-1). Fields not used by the chosen
//   direction come out as zero.
//   The datapath is a fully unrolled CORDIC pipeline: one multiply stage that
//   scales the start vector by the inverse gain, one stage that folds the vector
//   into the right half plane, one stage for each of the ITER_N micro-rotations,
//   and one rounding and saturation stage. A new transaction can be accepted in
//   every clock cycle, so the throughput is one item per cycle.
//   Each result appears on o_result for exactly one cycle with o_done high, after
//   the item has passed the multiply, fold, micro-rotation and output registers.
//   Results leave in the order the items came in.
//   The receiver cannot stall the block, and the pipeline never holds, so busy
//   is high only while reset is held.
//   Reset is synchronous and active low. It drops every item in flight; no
//   result is produced for them. Payload registers are not cleared.
`default_nettype none

module polar_rectangular_converter_unit
    import prc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_prc_in  i_item,
    output logic          o_done,
    output t_prc_out      o_result
);

    // Valid bits and vectors between the stages; index 0 is the front end output.
    logic     stg_valid [ITER_N+1];
    t_prc_vec stg_vec   [ITER_N+1];

    // The pipeline advances every cycle, so the only time an item is refused
    // is while reset holds the valid bits clear.
    assign busy = ~i_rst_n;

    // Pre-scale multiply and half-plane folding: two register stages.
    prc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_item  (i_item),
        .o_valid (stg_valid[0]),
        .o_vec   (stg_vec[0])
    );

    // One register stage per micro-rotation; the shift amount and the
    // arctangent entry of each stage are fixed by its position.
    for (genvar g = 0; g < ITER_N; g++) begin : g_iter
        prc_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_valid (stg_valid[g]),
            .i_vec   (stg_vec[g]),
            .o_valid (stg_valid[g+1]),
            .o_vec   (stg_vec[g+1])
        );
    end

    // Rounding, saturation and the result register that drives the ports.
    prc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stg_valid[ITER_N]),
        .i_vec    (stg_vec[ITER_N]),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

FILE: design/prc_checker.sv
// Port-level checks for the polar/rectangular converter, bound to the top level.
// Depends on prc_pkg for the pipeline latency and the result type.
`default_nettype none

module prc_checker
    import prc_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_start,
    input wire logic     i_busy,
    input wire logic     i_done,
    input wire t_prc_out i_result
);

    // Every accepted transaction yields its result after the fixed latency.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |-> ##LATENCY i_done)
        else $error("accepted transaction produced no result at the pipeline latency");

    // No result appears without a transaction accepted the latency before.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> $past(i_start && !i_busy, LATENCY))
        else $error("result without a matching accepted transaction");

    // Reset empties the pipeline.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_done)
        else $error("result strobe right after reset");

    // A polar result never carries rectangular coordinates.
    a_fields_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_done && ((i_result.radius_out != '0) || (i_result.angle_out != '0)))
            |-> ((i_result.x_out == '0) && (i_result.y_out == '0)))
        else $error("polar and rectangular result fields both nonzero");

endmodule

bind polar_rectangular_converter_unit prc_checker u_prc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (start),
    .i_busy   (busy),
    .i_done   (o_done),
    .i_result (o_result)
);

`default_nettype wire
